FILE: design/hset_pkg.sv
// Shared types, sizes and hash constants for the hashed integer set.
package hset_pkg;

   // Table geometry.
   localparam int NUM_BUCKETS      = 53;
   localparam int SLOTS_PER_BUCKET = 4;
   localparam int KEY_W            = 32;
   localparam int TOTAL_SLOTS      = NUM_BUCKETS * SLOTS_PER_BUCKET;
   localparam int BKT_W            = $clog2(NUM_BUCKETS);
   localparam int CNT_W            = $clog2(TOTAL_SLOTS + 1);
   localparam int COUNT_OUT_W      = 8;

   // Two to the power e, reduced modulo the bucket count.
   function automatic longint pow2_mod(int e);
      longint r;
      r = 1;
      for (int i = 0; i < e; i++) begin
         r = (r * 2) % NUM_BUCKETS;
      end
      return r;
   endfunction

   // Byte weights for folding a 32-bit word into a small sum.
   localparam longint W8       = pow2_mod(8);
   localparam longint W16      = pow2_mod(16);
   localparam longint W24      = pow2_mod(24);
   localparam longint W32      = pow2_mod(32);
   // Added for a negative key: minus two to the 32nd, taken modulo the bucket count.
   localparam longint SIGN_ADJ = (NUM_BUCKETS - W32) % NUM_BUCKETS;
   localparam longint SUM_MAX  = 255 * (1 + W8 + W16 + W24) + SIGN_ADJ;
   localparam int     SUM_W    = $clog2(SUM_MAX + 1);

   // Reciprocal for the reduction of the folded sum; the estimate is at most one low.
   localparam longint RECIP    = (longint'(1) << SUM_W) / NUM_BUCKETS;
   localparam int     RCP_W    = $clog2(RECIP + 1);
   localparam int     PROD_W   = SUM_W + RCP_W;

   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [RCP_W-1:0]  quot_type;
   typedef logic [BKT_W-1:0]  bucket_type;
   typedef logic [CNT_W-1:0]  count_type;

   // One bucket row as it sits in memory.
   typedef struct packed {
      logic [SLOTS_PER_BUCKET-1:0]            valid;
      logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0] keys;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   // Request kinds.
   typedef enum logic [1:0] {
      OP_CONTAINS = 2'd0,
      OP_INSERT   = 2'd1,
      OP_ERASE    = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_HASH   = 4'b0010,
      ST_REDUCE = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

endpackage

FILE: design/hset_ram.sv
// Generic single-write, single-read RAM with a registered read.
module hset_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/hashed_integer_set.sv
// Top level of the hashed integer set: hash sequencer, bucket RAM and update logic.
//
//   channel   ports                                   beat taken when
//   request   start, busy, req_operation, req_key     start && !busy
//   response  rsp_valid, rsp_done_ok,                 every cycle rsp_valid is high
//             rsp_bucket_full, rsp_stored_count
//
// A request beat is answered after the hash, reduce and update states, and busy
// stays high through them, so no new request is taken while one is in flight.
// These states hold the bucket hash (byte fold, reciprocal multiply, correction)
// and the registered read of the row that is then modified and written back.
// Reset and a clear request empty the table at once through per-row valid flops.
// The response is shown for one cycle and cannot be stalled.
module hashed_integer_set (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   output logic        rsp_done_ok,
   output logic        rsp_bucket_full,
   output logic [7:0]  rsp_stored_count
);

   localparam int SLOTS = hset_pkg::SLOTS_PER_BUCKET;

   hset_pkg::state_type  state_ff, state_in;
   hset_pkg::op_type     op_ff;
   logic [31:0]          key_ff;
   hset_pkg::sum_type    sum_ff, sum_in;
   hset_pkg::prod_type   prod_ff;
   hset_pkg::bucket_type bucket_ff, bucket_in;
   hset_pkg::count_type  count_ff, count_in;
   logic [hset_pkg::NUM_BUCKETS-1:0] row_valid_ff, row_valid_in;

   logic rsp_valid_ff, rsp_done_ok_ff, rsp_bucket_full_ff;
   logic [7:0] rsp_count_ff;

   logic accept;
   hset_pkg::quot_type quot;
   hset_pkg::sum_type  rem_est;

   logic [hset_pkg::ROW_W-1:0] ram_rd_data;
   hset_pkg::row_type row_rd, row_wr;
   logic [SLOTS-1:0]  valid_cur, hit, free, first_free;
   logic              found, wr_en, done_ok, bucket_full;

   assign accept = start && !busy;
   assign busy   = (state_ff != hset_pkg::ST_IDLE);

   // Fold the key bytes into a small sum that is congruent to the signed key.
   always_comb begin
      sum_in = hset_pkg::SUM_W'(req_key[7:0])
             + hset_pkg::SUM_W'(req_key[15:8])  * hset_pkg::SUM_W'(hset_pkg::W8)
             + hset_pkg::SUM_W'(req_key[23:16]) * hset_pkg::SUM_W'(hset_pkg::W16)
             + hset_pkg::SUM_W'(req_key[31:24]) * hset_pkg::SUM_W'(hset_pkg::W24)
             + (req_key[31] ? hset_pkg::SUM_W'(hset_pkg::SIGN_ADJ) : '0);
   end

   // Reduce the folded sum: quotient estimate, remainder, one correction.
   always_comb begin
      quot    = hset_pkg::RCP_W'(prod_ff >> hset_pkg::SUM_W);
      rem_est = sum_ff - hset_pkg::SUM_W'(hset_pkg::PROD_W'(quot)
                                          * hset_pkg::PROD_W'(hset_pkg::NUM_BUCKETS));
      if (rem_est >= hset_pkg::SUM_W'(hset_pkg::NUM_BUCKETS)) begin
         bucket_in = hset_pkg::BKT_W'(rem_est - hset_pkg::SUM_W'(hset_pkg::NUM_BUCKETS));
      end else begin
         bucket_in = hset_pkg::BKT_W'(rem_est);
      end
   end

   // Bucket row storage; the row is read in the reduce step and written in the update step.
   hset_ram #(
      .WIDTH (hset_pkg::ROW_W),
      .DEPTH (hset_pkg::NUM_BUCKETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (bucket_ff),
      .wr_data (row_wr),
      .rd_addr (bucket_in),
      .rd_data (ram_rd_data)
   );

   // Look up the key in the row; a row never written since the last clear is empty.
   always_comb begin
      row_rd    = hset_pkg::row_type'(ram_rd_data);
      valid_cur = row_valid_ff[bucket_ff] ? row_rd.valid : '0;
      for (int s = 0; s < SLOTS; s++) begin
         hit[s] = valid_cur[s] && (row_rd.keys[s] == key_ff);
      end
      found      = |hit;
      free       = ~valid_cur;
      first_free = free & (~free + SLOTS'(1));
   end

   // Modify the row and the count for the request kind.
   always_comb begin
      row_wr       = row_rd;
      row_wr.valid = valid_cur;
      wr_en        = 1'b0;
      done_ok      = 1'b0;
      bucket_full  = 1'b0;
      count_in     = count_ff;
      row_valid_in = row_valid_ff;
      if (state_ff == hset_pkg::ST_UPDATE) begin
         unique case (op_ff)
            hset_pkg::OP_CONTAINS: begin
               done_ok = found;
            end
            hset_pkg::OP_INSERT: begin
               if (!found) begin
                  if (free == '0) begin
                     bucket_full = 1'b1;
                  end else begin
                     done_ok      = 1'b1;
                     wr_en        = 1'b1;
                     row_wr.valid = valid_cur | first_free;
                     for (int s = 0; s < SLOTS; s++) begin
                        if (first_free[s]) begin
                           row_wr.keys[s] = key_ff;
                        end
                     end
                     count_in = count_ff + hset_pkg::CNT_W'(1);
                  end
               end
            end
            hset_pkg::OP_ERASE: begin
               if (found) begin
                  done_ok      = 1'b1;
                  wr_en        = 1'b1;
                  row_wr.valid = valid_cur & ~hit;
                  count_in     = count_ff - hset_pkg::CNT_W'(1);
               end
            end
            hset_pkg::OP_CLEAR: begin
               done_ok      = 1'b1;
               count_in     = '0;
               row_valid_in = '0;
            end
            default: begin
               done_ok = 1'b0;
            end
         endcase
         if (wr_en) begin
            row_valid_in[bucket_ff] = 1'b1;
         end
      end
   end

   // Sequencer: hash, reduce and read, then update and answer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hset_pkg::ST_IDLE:   if (accept) state_in = hset_pkg::ST_HASH;
         hset_pkg::ST_HASH:   state_in = hset_pkg::ST_REDUCE;
         hset_pkg::ST_REDUCE: state_in = hset_pkg::ST_UPDATE;
         hset_pkg::ST_UPDATE: state_in = hset_pkg::ST_IDLE;
         default:             state_in = hset_pkg::ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hset_pkg::ST_IDLE;
         count_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= (state_ff == hset_pkg::ST_UPDATE);
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= hset_pkg::op_type'(req_operation);
         key_ff <= req_key;
         sum_ff <= sum_in;
      end
      prod_ff <= hset_pkg::PROD_W'(sum_ff) * hset_pkg::PROD_W'(hset_pkg::RECIP);
      if (state_ff == hset_pkg::ST_REDUCE) begin
         bucket_ff <= bucket_in;
      end
      if (state_ff == hset_pkg::ST_UPDATE) begin
         rsp_done_ok_ff     <= done_ok;
         rsp_bucket_full_ff <= bucket_full;
         rsp_count_ff       <= hset_pkg::COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_done_ok      = rsp_done_ok_ff;
   assign rsp_bucket_full  = rsp_bucket_full_ff;
   assign rsp_stored_count = rsp_count_ff;

endmodule

FILE: design/hset_checker.sv
// Port-level checks for the hashed integer set, bound to the top level.
module hset_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_done_ok,
   input logic rsp_bucket_full
);

   // A taken request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a request beat");

   // Every taken request is answered after the hash, reduce and update states.
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("response beat missing four cycles after a request");

   // A response is only shown while the block is ready for the next request.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while busy");

   // A refused insert never reports success.
   a_full_not_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bucket_full) |-> !rsp_done_ok)
      else $error("bucket_full and done_ok together");

   // Reset leaves the block ready and silent.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind hashed_integer_set hset_checker u_hset_checker (.*);
